>>> rtl/nbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbr_pkg
// Shared types and constants for the normal blend and rotate block.
// ----------------------------------------------------------------------------
package nbr_pkg;

    localparam int MAX_NORMALS = 1024;
    localparam int FRAC_BITS   = 12;
    localparam int COMP_W      = 16;
    localparam int POS_W       = $clog2(MAX_NORMALS);
    localparam int CNT_W       = $clog2(MAX_NORMALS + 1);
    localparam int ROW_W       = 3 * COMP_W;
    localparam int DIFF_W      = COMP_W + 1;
    localparam int BPROD_W     = DIFF_W + COMP_W;
    localparam int MPROD_W     = 2 * COMP_W;
    localparam int SUM_W       = MPROD_W + 2;
    localparam int SHIFT_W     = SUM_W - FRAC_BITS;
    localparam int NSTAGE      = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = ROW_W;

    typedef logic signed [COMP_W-1:0]  comp_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [BPROD_W-1:0] bprod_t;
    typedef logic signed [MPROD_W-1:0] mprod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [SHIFT_W-1:0] shift_t;
    typedef logic [CNT_W-1:0]          slot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW0     = 3'd0,
        CFG_ROT_ROW1     = 3'd1,
        CFG_ROT_ROW2     = 3'd2,
        CFG_BLEND_ENABLE = 3'd3,
        CFG_BLEND_FACTOR = 3'd4
    } cfg_idx_t;

    localparam logic [ROW_W-1:0] ROW0_RESET = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RESET = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 48'h1000_0000_0000;

    localparam shift_t SAT_MAX = shift_t'(32767);
    localparam shift_t SAT_MIN = -shift_t'(32768);

endpackage

>>> rtl/nbr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbr_if
// Valid/ready channels for input normals and rotated result words.
// ----------------------------------------------------------------------------
interface nbr_in_if;
    logic                      valid;
    logic                      ready;
    nbr_pkg::comp_t            src_x;
    nbr_pkg::comp_t            src_y;
    nbr_pkg::comp_t            src_z;
    nbr_pkg::comp_t            alt_x;
    nbr_pkg::comp_t            alt_y;
    nbr_pkg::comp_t            alt_z;
    logic [nbr_pkg::POS_W-1:0] elem_pos;
    logic [nbr_pkg::CNT_W-1:0] elem_count;

    modport source (output valid, src_x, src_y, src_z, alt_x, alt_y, alt_z,
                    elem_pos, elem_count, input ready);
    modport sink   (input valid, src_x, src_y, src_z, alt_x, alt_y, alt_z,
                    elem_pos, elem_count, output ready);
endinterface

interface nbr_out_if;
    logic           valid;
    logic           ready;
    nbr_pkg::comp_t rot_x;
    nbr_pkg::comp_t rot_y;
    nbr_pkg::comp_t rot_z;
    nbr_pkg::slot_t slot;
    logic           last_of_mesh;

    modport source (output valid, rot_x, rot_y, rot_z, slot, last_of_mesh,
                    input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, slot, last_of_mesh,
                    output ready);
endinterface

>>> rtl/normal_blend_and_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_blend_and_rotate
// Blends a mesh normal toward an alternate vector, rotates it by a 3x3
// 4.12 matrix with saturation, and assigns its destination slot.
// ----------------------------------------------------------------------------
// Throughput: one word per clock unless the output stalls; six register
//   stages with per-stage valid, each stage advancing when empty or when the
//   stage after it moves.
// Reset: clears all stage valid bits, loads the identity matrix, blending off.
module normal_blend_and_rotate (
    input  logic                               clk,
    input  logic                               rst_n,
    nbr_in_if.sink                             in_ch,
    nbr_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [nbr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nbr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic [nbr_pkg::ROW_W-1:0] rot_row_reg [3];
    logic                      blend_en_reg;
    nbr_pkg::comp_t            blend_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row_reg[0]   <= nbr_pkg::ROW0_RESET;
            rot_row_reg[1]   <= nbr_pkg::ROW1_RESET;
            rot_row_reg[2]   <= nbr_pkg::ROW2_RESET;
            blend_en_reg     <= 1'b0;
            blend_factor_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (nbr_pkg::cfg_idx_t'(cfg_index))
                nbr_pkg::CFG_ROT_ROW0:     rot_row_reg[0] <= cfg_data;
                nbr_pkg::CFG_ROT_ROW1:     rot_row_reg[1] <= cfg_data;
                nbr_pkg::CFG_ROT_ROW2:     rot_row_reg[2] <= cfg_data;
                nbr_pkg::CFG_BLEND_ENABLE: blend_en_reg <= cfg_data[0];
                nbr_pkg::CFG_BLEND_FACTOR:
                    blend_factor_reg <= nbr_pkg::comp_t'(cfg_data[nbr_pkg::COMP_W-1:0]);
                default: ;
            endcase
        end
    end

    nbr_pkg::comp_t mat [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mat[i][j] = nbr_pkg::comp_t'(rot_row_reg[i][16*j +: 16]);
            end
        end
    end

    // stage flow control
    logic [nbr_pkg::NSTAGE:1] vld_reg;
    logic [nbr_pkg::NSTAGE:1] en;

    always_comb
    begin
        en[nbr_pkg::NSTAGE] = !vld_reg[nbr_pkg::NSTAGE] || out_ch.ready;
        for (int k = nbr_pkg::NSTAGE - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ch.ready = en[1];

    logic [nbr_pkg::NSTAGE:1] vld_next;

    always_comb
    begin
        vld_next = vld_reg;
        if (en[1])
        begin
            vld_next[1] = in_ch.valid;
        end
        for (int k = 2; k <= nbr_pkg::NSTAGE; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: input capture, blend difference, slot
    nbr_pkg::comp_t src_in [3];
    nbr_pkg::comp_t alt_in [3];
    nbr_pkg::comp_t s1_src_reg [3];
    nbr_pkg::diff_t s1_dif_reg [3];
    nbr_pkg::diff_t s1_dif_next [3];
    logic           s1_blend_reg;
    nbr_pkg::slot_t s1_slot_reg;
    nbr_pkg::slot_t s1_slot_next;
    logic           s1_last_reg;
    logic           s1_last_next;

    assign src_in[0] = in_ch.src_x;
    assign src_in[1] = in_ch.src_y;
    assign src_in[2] = in_ch.src_z;
    assign alt_in[0] = in_ch.alt_x;
    assign alt_in[1] = in_ch.alt_y;
    assign alt_in[2] = in_ch.alt_z;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            s1_dif_next[j] = $signed({alt_in[j][15], alt_in[j]})
                           - $signed({src_in[j][15], src_in[j]});
        end
        s1_slot_next = blend_en_reg
                     ? nbr_pkg::slot_t'(in_ch.elem_count - {1'b0, in_ch.elem_pos})
                     : {1'b0, in_ch.elem_pos};
        s1_last_next = ({1'b0, in_ch.elem_pos}
                        == nbr_pkg::slot_t'(in_ch.elem_count - nbr_pkg::slot_t'(1)));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_src_reg   <= src_in;
            s1_dif_reg   <= s1_dif_next;
            s1_blend_reg <= blend_en_reg;
            s1_slot_reg  <= s1_slot_next;
            s1_last_reg  <= s1_last_next;
        end
    end

    // stage 2: blend product
    nbr_pkg::comp_t  s2_src_reg [3];
    nbr_pkg::bprod_t s2_prod_reg [3];
    nbr_pkg::bprod_t s2_prod_next [3];
    logic            s2_blend_reg;
    nbr_pkg::slot_t  s2_slot_reg;
    logic            s2_last_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            s2_prod_next[j] = s1_dif_reg[j] * blend_factor_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_src_reg   <= s1_src_reg;
            s2_prod_reg  <= s2_prod_next;
            s2_blend_reg <= s1_blend_reg;
            s2_slot_reg  <= s1_slot_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // stage 3: floor shift and wrap-around add
    nbr_pkg::comp_t s3_vec_reg [3];
    nbr_pkg::comp_t s3_vec_next [3];
    nbr_pkg::slot_t s3_slot_reg;
    logic           s3_last_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            s3_vec_next[j] = s2_blend_reg
                ? nbr_pkg::comp_t'(s2_src_reg[j]
                    + s2_prod_reg[j][nbr_pkg::FRAC_BITS +: nbr_pkg::COMP_W])
                : s2_src_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_vec_reg  <= s3_vec_next;
            s3_slot_reg <= s2_slot_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // stage 4: matrix products
    nbr_pkg::mprod_t s4_mp_reg [3][3];
    nbr_pkg::mprod_t s4_mp_next [3][3];
    nbr_pkg::slot_t  s4_slot_reg;
    logic            s4_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s4_mp_next[i][j] = mat[i][j] * s3_vec_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_mp_reg   <= s4_mp_next;
            s4_slot_reg <= s3_slot_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // stage 5: row sums
    nbr_pkg::sum_t  s5_sum_reg [3];
    nbr_pkg::sum_t  s5_sum_next [3];
    nbr_pkg::slot_t s5_slot_reg;
    logic           s5_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_sum_next[i] = $signed({{2{s4_mp_reg[i][0][31]}}, s4_mp_reg[i][0]})
                           + $signed({{2{s4_mp_reg[i][1][31]}}, s4_mp_reg[i][1]})
                           + $signed({{2{s4_mp_reg[i][2][31]}}, s4_mp_reg[i][2]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_sum_reg  <= s5_sum_next;
            s5_slot_reg <= s4_slot_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // stage 6: floor shift and saturate, output register
    nbr_pkg::shift_t s5_sh [3];
    nbr_pkg::comp_t  s6_rot_reg [3];
    nbr_pkg::comp_t  s6_rot_next [3];
    nbr_pkg::slot_t  s6_slot_reg;
    logic            s6_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_sh[i] = nbr_pkg::shift_t'(s5_sum_reg[i][nbr_pkg::SUM_W-1:nbr_pkg::FRAC_BITS]);
            if (s5_sh[i] > nbr_pkg::SAT_MAX)
            begin
                s6_rot_next[i] = nbr_pkg::comp_t'(nbr_pkg::SAT_MAX);
            end
            else if (s5_sh[i] < nbr_pkg::SAT_MIN)
            begin
                s6_rot_next[i] = nbr_pkg::comp_t'(nbr_pkg::SAT_MIN);
            end
            else
            begin
                s6_rot_next[i] = nbr_pkg::comp_t'(s5_sh[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_rot_reg  <= s6_rot_next;
            s6_slot_reg <= s5_slot_reg;
            s6_last_reg <= s5_last_reg;
        end
    end

    assign out_ch.valid        = vld_reg[nbr_pkg::NSTAGE];
    assign out_ch.rot_x        = s6_rot_reg[0];
    assign out_ch.rot_y        = s6_rot_reg[1];
    assign out_ch.rot_z        = s6_rot_reg[2];
    assign out_ch.slot         = s6_slot_reg;
    assign out_ch.last_of_mesh = s6_last_reg;

`ifndef SYNTHESIS
    // input only backs up when every stage holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (&vld_reg))
        else $error("input stalled with a bubble in the pipeline");

    // a stalled full stage keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] && !en[4] |=> vld_reg[4] && $stable(s4_slot_reg))
        else $error("stage 4 word lost under stall");

    // positive overflow clamps to the maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] && en[6] && (s5_sh[0] > nbr_pkg::SAT_MAX)
        |=> out_ch.rot_x == nbr_pkg::comp_t'(nbr_pkg::SAT_MAX))
        else $error("rot_x not saturated high");

    // negative overflow clamps to the minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] && en[6] && (s5_sh[1] < nbr_pkg::SAT_MIN)
        |=> out_ch.rot_y == nbr_pkg::comp_t'(nbr_pkg::SAT_MIN))
        else $error("rot_y not saturated low");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the normal blend and rotate pipeline. Normal words
// are queued by a sequencer, driven by a clocked driver and predicted at the
// input handshake from a local copy of the registers. The monitor compares
// every rotated word with the oldest prediction. Phases vary the matrix, blend
// setting and source/sink pacing, with two long sink hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
    import nbr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int NUM_PHASES     = 8;
    localparam int CFG_IDX_LAST   = 2 ** CFG_IDX_W - 1;
    localparam int PRINT_LIMIT    = 40;

    typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

    typedef struct {
        comp_t            sx, sy, sz;
        comp_t            ax, ay, az;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
    } normal_word_t;

    typedef struct {
        comp_t rx, ry, rz;
        slot_t slot;
        logic  last;
    } rotated_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nbr_in_if  in_ch ();
    nbr_out_if out_ch ();

    normal_blend_and_rotate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register shadow
    logic [ROW_W-1:0] row_m [3];
    logic             blend_on_m;
    comp_t            factor_m;

    normal_word_t  pending_normals [$];
    rotated_word_t expected_rotated [$];
    normal_word_t  next_w;
    normal_word_t  seen_w;
    rotated_word_t exp_w;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   queued_total   = 0;
    int   accepted_total = 0;
    int   idle_cycles    = 0;
    int   err_count      = 0;
    logic in_fire        = 1'b0;
    logic hold_req       = 1'b0;
    logic rx_hold        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rotated_word_t rotate_normal(normal_word_t w);
        rotated_word_t r;
        longint        v [3];
        longint        alt [3];
        longint        d;
        longint        acc;
        comp_t         res [3];
        v[0] = w.sx;
        v[1] = w.sy;
        v[2] = w.sz;
        alt[0] = w.ax;
        alt[1] = w.ay;
        alt[2] = w.az;
        if (blend_on_m)
        begin
            for (int j = 0; j < 3; j++)
            begin
                d = ((alt[j] - v[j]) * longint'(factor_m)) >>> FRAC_BITS;
                v[j] = longint'(comp_t'(v[j] + d));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += longint'(comp_t'(row_m[i][16*j +: 16])) * v[j];
            acc = acc >>> FRAC_BITS;
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
            res[i] = comp_t'(acc);
        end
        r.rx   = res[0];
        r.ry   = res[1];
        r.rz   = res[2];
        r.slot = blend_on_m ? slot_t'(w.cnt - w.pos) : slot_t'(w.pos);
        r.last = ({1'b0, w.pos} == slot_t'(w.cnt - 1));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // driver: input words and sink ready change on the falling edge
    always @(negedge clk)
    begin
        if (!in_ch.valid || in_fire)
        begin
            if (pending_normals.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_w = pending_normals.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.src_x      <= next_w.sx;
                in_ch.src_y      <= next_w.sy;
                in_ch.src_z      <= next_w.sz;
                in_ch.alt_x      <= next_w.ax;
                in_ch.alt_y      <= next_w.ay;
                in_ch.alt_z      <= next_w.az;
                in_ch.elem_pos   <= next_w.pos;
                in_ch.elem_count <= next_w.cnt;
            end
            else
                in_ch.valid <= 1'b0;
        end
        out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict at input accept, check at output accept
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                seen_w.sx  = in_ch.src_x;
                seen_w.sy  = in_ch.src_y;
                seen_w.sz  = in_ch.src_z;
                seen_w.ax  = in_ch.alt_x;
                seen_w.ay  = in_ch.alt_y;
                seen_w.az  = in_ch.alt_z;
                seen_w.pos = in_ch.elem_pos;
                seen_w.cnt = in_ch.elem_count;
                expected_rotated.push_back(rotate_normal(seen_w));
                accepted_total++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_rotated.size() == 0)
                    report_mismatch("result word with no word pending");
                else
                begin
                    exp_w = expected_rotated.pop_front();
                    if (out_ch.rot_x !== exp_w.rx)
                        report_mismatch($sformatf("rot_x got %0d exp %0d",
                                                  out_ch.rot_x, exp_w.rx));
                    if (out_ch.rot_y !== exp_w.ry)
                        report_mismatch($sformatf("rot_y got %0d exp %0d",
                                                  out_ch.rot_y, exp_w.ry));
                    if (out_ch.rot_z !== exp_w.rz)
                        report_mismatch($sformatf("rot_z got %0d exp %0d",
                                                  out_ch.rot_z, exp_w.rz));
                    if (out_ch.slot !== exp_w.slot)
                        report_mismatch($sformatf("slot got %0d exp %0d",
                                                  out_ch.slot, exp_w.slot));
                    if (out_ch.last_of_mesh !== exp_w.last)
                        report_mismatch($sformatf("last_of_mesh got %0b exp %0b",
                                                  out_ch.last_of_mesh, exp_w.last));
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // long sink hold-off, counted here
    initial
    begin
        forever
        begin
            wait (hold_req);
            @(posedge clk);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold  = 1'b0;
            hold_req = 1'b0;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [ROW_W-1:0] random48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic comp_t random_comp();
        case ($urandom_range(9))
            0: return comp_t'(32767);
            1: return comp_t'(-32768);
            2: return comp_t'(0);
            3: return comp_t'($urandom_range(8191)) - comp_t'(4096);
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        return {random_comp(), random_comp(), random_comp()};
    endfunction

    function automatic normal_word_t random_normal();
        normal_word_t w;
        int           cnt;
        w.sx = random_comp();
        w.sy = random_comp();
        w.sz = random_comp();
        w.ax = random_comp();
        w.ay = random_comp();
        w.az = random_comp();
        cnt  = $urandom_range(MAX_NORMALS, 1);
        w.cnt = CNT_W'(cnt);
        case ($urandom_range(9))
            0:
            begin
                w.cnt = CNT_W'($urandom);
                w.pos = POS_W'($urandom);
            end
            1, 2, 3: w.pos = POS_W'(cnt - 1);
            default: w.pos = POS_W'($urandom_range(cnt - 1));
        endcase
        return w;
    endfunction

    function automatic normal_word_t make_normal(int sx, int sy, int sz, int ax, int ay,
                                                 int az, int pos, int cnt);
        normal_word_t w;
        w.sx  = comp_t'(sx);
        w.sy  = comp_t'(sy);
        w.sz  = comp_t'(sz);
        w.ax  = comp_t'(ax);
        w.ay  = comp_t'(ay);
        w.az  = comp_t'(az);
        w.pos = POS_W'(pos);
        w.cnt = CNT_W'(cnt);
        return w;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ROT_ROW0:     row_m[0] = data;
            CFG_ROT_ROW1:     row_m[1] = data;
            CFG_ROT_ROW2:     row_m[2] = data;
            CFG_BLEND_ENABLE: blend_on_m = data[0];
            CFG_BLEND_FACTOR: factor_m = comp_t'(data[COMP_W-1:0]);
            default: ;
        endcase
    endtask

    // unused upper data bits carry junk
    task automatic set_config(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                              input logic [ROW_W-1:0] r2, input logic en, input comp_t f);
        logic [CFG_DATA_W-1:0] junk;
        junk = random48();
        cfg_write(CFG_ROT_ROW0, r0);
        cfg_write(CFG_ROT_ROW1, r1);
        cfg_write(CFG_ROT_ROW2, r2);
        cfg_write(CFG_BLEND_ENABLE, {junk[CFG_DATA_W-1:1], en});
        cfg_write(CFG_BLEND_FACTOR, {junk[CFG_DATA_W-1:COMP_W], f});
    endtask

    task automatic start_phase(input pace_t pace);
        @(posedge clk);
        case (pace)
            PACE_FULL:      begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SRC_IDLE:  begin send_idle_pct = 55; recv_stall_pct = 0;  end
            PACE_SNK_STALL: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default:        begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    task automatic queue_normal(input normal_word_t w);
        pending_normals.push_back(w);
        queued_total++;
    endtask

    task automatic drain();
        @(negedge clk);
        while (accepted_total != queued_total || expected_rotated.size() != 0)
            @(negedge clk);
        repeat (NSTAGE + 2) @(negedge clk);
    endtask

    initial
    begin
        comp_t f;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.src_x      = '0;
        in_ch.src_y      = '0;
        in_ch.src_z      = '0;
        in_ch.alt_x      = '0;
        in_ch.alt_y      = '0;
        in_ch.alt_z      = '0;
        in_ch.elem_pos   = '0;
        in_ch.elem_count = '0;
        out_ch.ready     = 1'b0;
        row_m[0]   = ROW0_RESET;
        row_m[1]   = ROW1_RESET;
        row_m[2]   = ROW2_RESET;
        blend_on_m = 1'b0;
        factor_m   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset registers: identity, no blend
        start_phase(PACE_FULL);
        queue_normal(make_normal(0, 0, 0, 0, 0, 0, 0, 1));
        queue_normal(make_normal(32767, 32767, 32767, -32768, -32768, -32768, 1023, 1024));
        queue_normal(make_normal(-32768, -32768, -32768, 32767, 32767, 32767, 0, 1024));
        queue_normal(make_normal(-1, 4096, -4096, 1, 2, 3, 1023, 0));
        queue_normal(make_normal(100, -200, 300, 0, 0, 0, 5, 2047));
        queue_normal(make_normal(7, 8, 9, 10, 11, 12, 10, 5));
        queue_normal(make_normal(0, 0, 0, 0, 0, 0, 1023, 2047));
        queue_normal(make_normal(21845, -21846, 10922, 0, 0, 0, 4, 5));
        drain();

        // saturating matrix, blend toward alternate with wrap
        for (int i = int'(CFG_BLEND_FACTOR) + 1; i <= CFG_IDX_LAST; i++)
            cfg_write(CFG_IDX_W'(i), random48());
        set_config({3{16'h7FFF}}, {3{16'h8000}}, {16'h7FFF, 16'h8000, 16'h0000},
                   1'b1, comp_t'(-32768));
        start_phase(PACE_FULL);
        queue_normal(make_normal(-32768, -32768, -32768, 32767, 32767, 32767, 0, 1));
        queue_normal(make_normal(32767, 32767, 32767, -32768, -32768, -32768, 1023, 1024));
        queue_normal(make_normal(1000, -1000, 0, 1000, -1000, 0, 10, 5));
        queue_normal(make_normal(0, 0, 0, 0, 0, 0, 0, 0));
        queue_normal(make_normal(-32768, 0, 32767, 0, -32768, 32767, 1023, 2047));
        queue_normal(make_normal(4096, 4096, 4096, -4096, -4096, -4096, 3, 4));
        drain();
        set_config(ROW0_RESET, ROW1_RESET, ROW2_RESET, 1'b1, comp_t'(32767));
        start_phase(PACE_FULL);
        queue_normal(make_normal(-32768, 32767, 0, 32767, -32768, -1, 2, 3));
        queue_normal(make_normal(12, -34, 56, -78, 90, -12, 700, 1000));
        queue_normal(make_normal(1, 1, 1, 1, 1, 1, 0, 2));
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: set_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                              1'b1, comp_t'(-32768));
                1: set_config({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                              1'b1, comp_t'(32767));
                2: set_config(random_row(), random_row(), random_row(), 1'b0,
                              comp_t'($urandom));
                default:
                begin
                    case ($urandom_range(4))
                        0: f = comp_t'(4096);
                        1: f = comp_t'(0);
                        2: f = comp_t'(-4096);
                        default: f = comp_t'($urandom);
                    endcase
                    set_config(random_row(), random_row(), random_row(),
                               1'($urandom_range(1)), f);
                end
            endcase
            start_phase(pace_t'(p % 4));
            if (p == 2 || p == 6)
                hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                queue_normal(random_normal());
            drain();
        end

        repeat (4 * NSTAGE) @(negedge clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/nbr_pkg.sv
rtl/nbr_if.sv
rtl/normal_blend_and_rotate.sv
tb/tb_top.sv
